// ----- sv/apsc_pkg.sv -----
// Shared types, constants and lookup tables for the sample-playback channel.
// Used by every module of the channel but apsc_state_ram; depends on nothing else.
`default_nettype none

package apsc_pkg;

  localparam int ADDR_W       = 29;
  localparam int ALIGN_W      = 6;
  localparam int SAMPLE_W     = 12;
  localparam int STEP_POS_W   = 7;
  localparam int STEP_W       = 15;
  localparam int PERIOD_W     = 8;
  localparam int ROM_SIZE_W   = 30;
  localparam int OUT_W        = 15;
  localparam int OUT_SHIFT    = 3;
  localparam int CFG_INDEX_W  = 2;
  localparam int BYTE_W       = 8;

  localparam logic [PERIOD_W-1:0]        PERIOD_RESET   = 8'h6F;
  localparam logic [ROM_SIZE_W-1:0]      ROM_SIZE_RESET = 30'd4194304;
  localparam logic [STEP_POS_W-1:0]      STEP_POS_MAX   = 7'd88;
  localparam logic signed [SAMPLE_W-1:0] PRED_MAX       = 12'sd2047;
  localparam logic signed [SAMPLE_W-1:0] PRED_MIN       = -12'sd2048;
  localparam logic [BYTE_W-1:0]          END_BYTE       = 8'hFF;
  localparam logic [BYTE_W-1:0]          ZERO_BYTE      = 8'h00;

  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROM_SIZE      = 2'd1;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef struct packed {
    logic [PERIOD_W-1:0]        tick_count;
    logic [ADDR_W-1:0]          read_address;
    logic                       playing;
    logic                       adpcm;
    logic signed [SAMPLE_W-1:0] predictor;
    logic [STEP_POS_W-1:0]      step_pos;
    logic                       low_nibble;
    logic signed [SAMPLE_W-1:0] sample;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

  typedef struct packed {
    op_t               op;
    logic              adpcm_mode;
    logic [ADDR_W-1:0] start_address;
    logic [BYTE_W-1:0] b0;
    logic [BYTE_W-1:0] b1;
    logic [BYTE_W-1:0] b2;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [ADDR_W-1:0] value;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [ADDR_W-1:0] result;
  } mod_rsp_t;

  function automatic logic [STEP_W-1:0] step_size(input logic [STEP_POS_W-1:0] pos);
    logic [STEP_W-1:0] s;
    unique case (pos)
      7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;     7'd3:  s = 15'd10;
      7'd4:  s = 15'd11;    7'd5:  s = 15'd12;    7'd6:  s = 15'd13;    7'd7:  s = 15'd14;
      7'd8:  s = 15'd16;    7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
      7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;    7'd15: s = 15'd31;
      7'd16: s = 15'd34;    7'd17: s = 15'd37;    7'd18: s = 15'd41;    7'd19: s = 15'd45;
      7'd20: s = 15'd50;    7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
      7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;    7'd27: s = 15'd97;
      7'd28: s = 15'd107;   7'd29: s = 15'd118;   7'd30: s = 15'd130;   7'd31: s = 15'd143;
      7'd32: s = 15'd157;   7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
      7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;   7'd39: s = 15'd307;
      7'd40: s = 15'd337;   7'd41: s = 15'd371;   7'd42: s = 15'd408;   7'd43: s = 15'd449;
      7'd44: s = 15'd494;   7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
      7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;   7'd51: s = 15'd963;
      7'd52: s = 15'd1060;  7'd53: s = 15'd1166;  7'd54: s = 15'd1282;  7'd55: s = 15'd1411;
      7'd56: s = 15'd1552;  7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
      7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;  7'd63: s = 15'd3024;
      7'd64: s = 15'd3327;  7'd65: s = 15'd3660;  7'd66: s = 15'd4026;  7'd67: s = 15'd4428;
      7'd68: s = 15'd4871;  7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
      7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;  7'd75: s = 15'd9493;
      7'd76: s = 15'd10442; 7'd77: s = 15'd11487; 7'd78: s = 15'd12635; 7'd79: s = 15'd13899;
      7'd80: s = 15'd15289; 7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
      7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086; 7'd87: s = 15'd29794;
      default: s = 15'd32767;
    endcase
    return s;
  endfunction

  function automatic logic signed [3:0] index_adjust(input logic [2:0] code);
    logic signed [3:0] a;
    unique case (code)
      3'd4:    a = 4'sd1;
      3'd5:    a = 4'sd2;
      3'd6:    a = 4'sd4;
      3'd7:    a = 4'sd6;
      default: a = -4'sd1;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/apsc_state_ram.sv -----
// Single-entry channel state memory with a registered read port.
// Generic over width; an entry that was never written reads as zero.
`default_nettype none

module apsc_state_ram #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             we,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:0];
  logic             written;
  logic             rd_valid;
  logic [WIDTH-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[0] <= wdata;
    end
    if (re) begin
      rd_data <= mem[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written  <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (we) begin
        written <= 1'b1;
      end
      if (re) begin
        rd_valid <= written;
      end
    end
  end

  assign rdata = rd_valid ? rd_data : '0;

endmodule

`default_nettype wire

// ----- sv/apsc_addr_mod.sv -----
// Address reduction unit: remainder of an address by the ROM size.
// Radix-2 restoring remainder, one bit per cycle; uses apsc_pkg.
`default_nettype none

module apsc_addr_mod (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire apsc_pkg::mod_req_t                   req,
  input  wire logic [apsc_pkg::ROM_SIZE_W-1:0]      modulus,
  output apsc_pkg::mod_rsp_t                        rsp
);

  import apsc_pkg::*;

  localparam int CNT_W = $clog2(ADDR_W + 1);

  logic                  busy;
  logic                  done;
  logic [CNT_W-1:0]      cnt;
  logic [ADDR_W-1:0]     val;
  logic [ADDR_W-1:0]     rem;
  logic [ADDR_W-1:0]     rem_next;
  logic [ROM_SIZE_W-1:0] shifted;
  logic [ROM_SIZE_W-1:0] diff;
  logic                  fits;

  assign fits    = {1'b0, req.value} < modulus;
  assign shifted = {rem, val[ADDR_W-1]};
  assign diff    = shifted - modulus;

  always_comb begin
    if (shifted >= modulus) begin
      rem_next = diff[ADDR_W-1:0];
    end else begin
      rem_next = shifted[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= !fits;
        done <= fits;
      end else if (busy && cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      val <= req.value;
      cnt <= CNT_W'(ADDR_W);
      if (fits) begin
        rem <= req.value;
      end else begin
        rem <= '0;
      end
    end else if (busy) begin
      val <= {val[ADDR_W-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
      rem <= rem_next;
    end
  end

  assign rsp.done   = done;
  assign rsp.result = rem;

endmodule

`default_nettype wire

// ----- sv/apsc_decode.sv -----
// Next-state logic for one transaction: start, stop, tick and element decode.
// Combinational; uses apsc_pkg for the state record and the ADPCM tables.
`default_nettype none

module apsc_decode (
  input  wire apsc_pkg::chan_state_t              cur,
  input  wire apsc_pkg::item_t                    item,
  input  wire logic [apsc_pkg::ADDR_W-1:0]        red_addr,
  input  wire logic [apsc_pkg::PERIOD_W-1:0]      sample_period,
  output apsc_pkg::chan_state_t                   nxt,
  output logic                                    did
);

  import apsc_pkg::*;

  logic [STEP_POS_W-1:0]      pos_c;
  logic [STEP_W-1:0]          step;
  logic [3:0]                 nib;
  logic [STEP_W:0]            mag;
  logic signed [SAMPLE_W+5:0] sum;
  logic signed [SAMPLE_W-1:0] pred_sat;
  logic signed [BYTE_W-1:0]   pos;
  logic [STEP_POS_W-1:0]      pos_next;
  logic                       adpcm_end;

  assign pos_c     = (cur.step_pos > STEP_POS_MAX) ? STEP_POS_MAX : cur.step_pos;
  assign step      = step_size(pos_c);
  assign nib       = cur.low_nibble ? item.b0[3:0] : item.b0[7:4];
  assign adpcm_end = (item.b0 == ZERO_BYTE) && (item.b1 == ZERO_BYTE) && (item.b2 == END_BYTE);

  always_comb begin
    mag = 16'(step >> 3);
    if (nib[2]) mag = mag + 16'(step);
    if (nib[1]) mag = mag + 16'(step >> 1);
    if (nib[0]) mag = mag + 16'(step >> 2);
    if (nib[3]) begin
      sum = 18'(cur.predictor) - $signed({2'b00, mag});
    end else begin
      sum = 18'(cur.predictor) + $signed({2'b00, mag});
    end
    if (sum > 18'(PRED_MAX)) begin
      pred_sat = PRED_MAX;
    end else if (sum < 18'(PRED_MIN)) begin
      pred_sat = PRED_MIN;
    end else begin
      pred_sat = sum[SAMPLE_W-1:0];
    end
    pos = $signed({1'b0, pos_c}) + 8'(index_adjust(nib[2:0]));
    if (pos < 8'sd0) begin
      pos_next = '0;
    end else if (pos > $signed({1'b0, STEP_POS_MAX})) begin
      pos_next = STEP_POS_MAX;
    end else begin
      pos_next = pos[STEP_POS_W-1:0];
    end
  end

  always_comb begin
    nxt = cur;
    did = 1'b0;
    unique case (item.op)
      OP_START: begin
        nxt.adpcm = item.adpcm_mode;
        if (item.adpcm_mode) begin
          nxt.predictor  = '0;
          nxt.step_pos   = '0;
          nxt.low_nibble = 1'b0;
        end
        nxt.sample       = '0;
        nxt.tick_count   = '0;
        nxt.read_address = {item.start_address[ADDR_W-1:ALIGN_W], ALIGN_W'(0)};
        nxt.playing      = 1'b1;
      end
      OP_STOP: begin
        nxt.sample     = '0;
        nxt.tick_count = '0;
        nxt.playing    = 1'b0;
        did            = 1'b1;
      end
      OP_TICK: begin
        if (cur.playing) begin
          if (cur.tick_count == '0) begin
            did = 1'b1;
            nxt.read_address = red_addr;
            if (cur.adpcm) begin
              if (adpcm_end) begin
                nxt.sample  = '0;
                nxt.playing = 1'b0;
              end else begin
                if (cur.low_nibble) begin
                  nxt.read_address = red_addr + ADDR_W'(1);
                end
                nxt.low_nibble = !cur.low_nibble;
                nxt.predictor  = pred_sat;
                nxt.sample     = pred_sat;
                nxt.step_pos   = pos_next;
              end
            end else begin
              nxt.read_address = red_addr + ADDR_W'(1);
              if (item.b0 == END_BYTE) begin
                nxt.sample  = '0;
                nxt.playing = 1'b0;
              end else begin
                nxt.sample = {~item.b0[7], item.b0[6:0], 4'b0000};
              end
            end
            if (nxt.playing) begin
              nxt.tick_count = sample_period - PERIOD_W'(1);
            end else begin
              nxt.tick_count = '0;
            end
          end else begin
            nxt.tick_count = cur.tick_count - PERIOD_W'(1);
          end
        end
      end
      OP_NONE: begin
        did = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/adpcm_pcm_sample_channel.sv -----
// A transaction reduces the stored fetch address, decodes, reduces the new fetch address and
// writes its result; an address below rom_size leaves the bit-serial remainder unit at once.
// One transaction is in flight at a time; the result register is loaded once result_stall
// frees it, and the next transaction is taken in the cycle after that load at the earliest.
// Synchronous active-high reset clears the channel state, the registers return to
// sample_period 111 and rom_size 4194304, and no result is pending.
`default_nettype none

module adpcm_pcm_sample_channel (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   item_valid,
  output logic                                        item_stall,
  input  wire logic [1:0]                             op,
  input  wire logic                                   adpcm_mode,
  input  wire logic [apsc_pkg::ADDR_W-1:0]            start_address,
  input  wire logic [apsc_pkg::BYTE_W-1:0]            rom_byte0,
  input  wire logic [apsc_pkg::BYTE_W-1:0]            rom_byte1,
  input  wire logic [apsc_pkg::BYTE_W-1:0]            rom_byte2,
  output logic                                        result_valid,
  input  wire logic                                   result_stall,
  output logic signed [apsc_pkg::OUT_W-1:0]           sample_out,
  output logic                                        is_playing,
  output logic [apsc_pkg::ADDR_W-1:0]                 fetch_address,
  output logic                                        decoded,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [apsc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  wire logic [apsc_pkg::ROM_SIZE_W-1:0]        cfg_data
);

  import apsc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_LOAD    = 6'b000010,
    S_MOD_OLD = 6'b000100,
    S_EXEC    = 6'b001000,
    S_MOD_NEW = 6'b010000,
    S_WRITE   = 6'b100000
  } state_t;

  state_t                state;
  state_t                state_next;
  logic [PERIOD_W-1:0]   sample_period;
  logic [ROM_SIZE_W-1:0] rom_size;
  item_t                 item;
  chan_state_t           cur;
  chan_state_t           ram_q;
  chan_state_t           dec_next;
  logic                  dec_did;
  logic                  did;
  mod_req_t              mod_req;
  mod_rsp_t              mod_rsp;
  logic                  item_take;
  logic                  out_free;
  logic                  out_load;

  assign item_stall = (state != S_IDLE);
  assign item_take  = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign out_load   = (state == S_WRITE) && out_free;
  assign cfg_ready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_period <= PERIOD_RESET;
      rom_size      <= ROM_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_SAMPLE_PERIOD && cfg_data[PERIOD_W-1:0] != '0) begin
        sample_period <= cfg_data[PERIOD_W-1:0];
      end
      if (cfg_index == REG_ROM_SIZE && cfg_data != '0) begin
        rom_size <= cfg_data;
      end
    end
  end

  apsc_state_ram #(
    .WIDTH (STATE_W)
  ) u_state_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (out_load),
    .wdata (cur),
    .re    (item_take),
    .rdata (ram_q)
  );

  always_comb begin
    mod_req.start = (state == S_LOAD) || (state == S_EXEC);
    if (state == S_LOAD) begin
      mod_req.value = ram_q.read_address;
    end else begin
      mod_req.value = dec_next.read_address;
    end
  end

  apsc_addr_mod u_addr_mod (
    .clk     (clk),
    .rst     (rst),
    .req     (mod_req),
    .modulus (rom_size),
    .rsp     (mod_rsp)
  );

  apsc_decode u_decode (
    .cur           (cur),
    .item          (item),
    .red_addr      (mod_rsp.result),
    .sample_period (sample_period),
    .nxt           (dec_next),
    .did           (dec_did)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (item_take) state_next = S_LOAD;
      S_LOAD:    state_next = S_MOD_OLD;
      S_MOD_OLD: if (mod_rsp.done) state_next = S_EXEC;
      S_EXEC:    state_next = S_MOD_NEW;
      S_MOD_NEW: if (mod_rsp.done) state_next = S_WRITE;
      S_WRITE:   if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      item.op            <= op_t'(op);
      item.adpcm_mode    <= adpcm_mode;
      item.start_address <= start_address;
      item.b0            <= rom_byte0;
      item.b1            <= rom_byte1;
      item.b2            <= rom_byte2;
    end
    if (state == S_LOAD) begin
      cur <= ram_q;
    end else if (state == S_EXEC) begin
      cur <= dec_next;
      did <= dec_did;
    end
    if (out_load) begin
      sample_out    <= {cur.sample, OUT_SHIFT'(0)};
      is_playing    <= cur.playing;
      fetch_address <= mod_rsp.result;
      decoded       <= did;
    end
  end

endmodule

`default_nettype wire

// ----- sv/apsc_checker.sv -----
// Port-level checks for the sample-playback channel, bound to the top level.
// Uses apsc_pkg for the port widths.
`default_nettype none

module apsc_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              item_valid,
  input wire logic                              item_stall,
  input wire logic                              result_valid,
  input wire logic                              result_stall,
  input wire logic signed [apsc_pkg::OUT_W-1:0] sample_out,
  input wire logic                              is_playing,
  input wire logic [apsc_pkg::ADDR_W-1:0]       fetch_address,
  input wire logic                              decoded
);

  import apsc_pkg::*;

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result pending after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(sample_out) &&
      $stable(is_playing) && $stable(fetch_address) && $stable(decoded))
    else $error("stalled result changed");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("second transaction taken while one is in flight");

  a_silent_when_stopped: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_playing |-> sample_out == '0)
    else $error("stopped channel reports a nonzero sample");

  a_scaled_output: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> sample_out[OUT_SHIFT-1:0] == '0)
    else $error("output sample is not a scaled decoder value");

endmodule

bind adpcm_pcm_sample_channel apsc_checker u_apsc_checker (
  .clk           (clk),
  .rst           (rst),
  .item_valid    (item_valid),
  .item_stall    (item_stall),
  .result_valid  (result_valid),
  .result_stall  (result_stall),
  .sample_out    (sample_out),
  .is_playing    (is_playing),
  .fetch_address (fetch_address),
  .decoded       (decoded)
);

`default_nettype wire
